### src/mqrb_pkg.sv
// Shared constants for the multi-queue packet ring buffer.
// Field widths, stream packing widths, action codes and default sizes.
// No dependencies; every other file in src imports this package.
package mqrb_pkg;

	// default sizes handed to the top-level parameters
	localparam int NUM_QUEUES_DEF      = 4;
	localparam int RING_DEPTH_DEF      = 16;
	localparam int WORDS_PER_ENTRY_DEF = 512;

	// field widths
	localparam int ACTION_W = 2;
	localparam int PORT_W   = 16;
	localparam int SEQ_W    = 16;
	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 5;

	// stream packing
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 2;

	// request kinds carried in s_tuser
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_RSVD  = 2'd3;

endpackage

### src/mqrb_ram.sv
// Single-port synchronous RAM with registered read data, no reset on contents.
// Holds the payload words and the per-slot entry lengths. Uses mqrb_pkg.
module mqrb_ram #(
	parameter int DW    = mqrb_pkg::SAMPLE_W,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);
	import mqrb_pkg::*;

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// write, or register the read word
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### src/mqrb_vram.sv
// Small two-port RAM with a valid bit per entry; unwritten entries read zero.
// Holds the per-queue ring record (head, tail, count, sequence, read offset). Uses mqrb_pkg.
module mqrb_vram #(
	parameter int DW    = 32,
	parameter int DEPTH = mqrb_pkg::NUM_QUEUES_DEF,
	parameter int AW    = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	import mqrb_pkg::*;

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0]    rd_q;
	logic             rv_q;

	// store contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// track written entries and the validity of the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rv_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rv_q ? rd_q : '0;

endmodule

### src/multi_queue_packet_ring_buffer.sv
// Top level of the multi-queue packet ring buffer: request sequencer, write-packet
// tracking and result register around mqrb_vram (queue records) and two mqrb_ram
// instances (payload words, entry lengths). Uses mqrb_pkg.
//
//  channel  | direction | signals                          | contents
//  ---------+-----------+----------------------------------+-------------------------------
//  cfg      | in        | cfg_valid cfg_ready cfg_data     | base_port
//  s (req)  | in        | s_tvalid s_tready s_tdata        | port, seq, data_in
//           |           | s_tuser s_tlast                  | action; last_in
//  m (res)  | out       | m_tvalid m_tready m_tdata        | data_out, entry_count (+pad)
//           |           | m_tuser m_tlast                  | data_valid, write_accepted; entry_last
//
// Write, query, reserved and missed read requests fetch the queue record from its RAM,
// then update it; a read hit also fetches the payload word and entry length before
// its record update. The next request is taken while the last result waits in m.
// A result held in m with m_tready low stalls completion of the following request.
// Reset clears control state and the record valid bits; no clearing pass is needed.
module multi_queue_packet_ring_buffer #(
	parameter int NUM_QUEUES      = mqrb_pkg::NUM_QUEUES_DEF,
	parameter int RING_DEPTH      = mqrb_pkg::RING_DEPTH_DEF,
	parameter int WORDS_PER_ENTRY = mqrb_pkg::WORDS_PER_ENTRY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mqrb_pkg::PORT_W-1:0]    cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mqrb_pkg::S_TDATA_W-1:0] s_tdata,  // [15:0] port, [31:16] seq, [47:32] data_in
	input  logic [mqrb_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] action
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mqrb_pkg::M_TDATA_W-1:0] m_tdata,  // [15:0] data_out, [20:16] entry_count, [23:21] 0
	output logic [mqrb_pkg::M_TUSER_W-1:0] m_tuser,  // [0] data_valid, [1] write_accepted
	output logic                           m_tlast
);
	import mqrb_pkg::*;

	localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW    = $clog2(RING_DEPTH);
	localparam int CW    = $clog2(RING_DEPTH + 1);
	localparam int OW    = (WORDS_PER_ENTRY > 1) ? $clog2(WORDS_PER_ENTRY) : 1;
	localparam int LW    = $clog2(WORDS_PER_ENTRY + 1);
	localparam int SLOTS = NUM_QUEUES * RING_DEPTH;
	localparam int SW    = $clog2(SLOTS);
	localparam int WORDS = SLOTS * WORDS_PER_ENTRY;
	localparam int AW    = $clog2(WORDS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	typedef struct packed {
		logic [PW-1:0]    head;
		logic [PW-1:0]    tail;
		logic [CW-1:0]    total;
		logic [SEQ_W-1:0] latest;
		logic [OW-1:0]    roff;
	} qrec_t;

	localparam int QRW = $bits(qrec_t);

	function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
		ring_inc = (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [SW-1:0] slot_of(input logic [QW-1:0] q, input logic [PW-1:0] p);
		slot_of = SW'(q) * SW'(RING_DEPTH) + SW'(p);
	endfunction

	function automatic logic [AW-1:0] word_of(input logic [SW-1:0] s, input logic [OW-1:0] o);
		word_of = AW'(s) * AW'(WORDS_PER_ENTRY) + AW'(o);
	endfunction

	// control and configuration
	logic [1:0]        state_q;
	logic [PORT_W-1:0] base_q;
	logic              wbusy_q, wdrop_q;
	logic [QW-1:0]     wq_q;
	logic [LW-1:0]     woff_q;

	// request held through execution
	logic [ACTION_W-1:0] act_s1;
	logic [QW-1:0]       q_s1;
	logic                served_s1;
	logic [SEQ_W-1:0]    seq_s1;
	logic [SAMPLE_W-1:0] data_s1;
	logic                last_s1;

	// result register
	logic                m_valid_q;
	logic [SAMPLE_W-1:0] dout_q;
	logic                dval_q, elast_q, wacc_q;
	logic [COUNT_W-1:0]  cnt_q;

	// request decode
	logic [ACTION_W-1:0] in_act;
	logic [PORT_W-1:0]   in_qdiff;
	logic                in_served;
	logic                in_acc;
	logic [QW-1:0]       qs_raddr;

	assign in_act    = s_tuser[ACTION_W-1:0];
	assign in_qdiff  = s_tdata[PORT_W-1:0] - base_q;
	assign in_served = in_qdiff < PORT_W'(NUM_QUEUES);
	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign qs_raddr  = (in_act == ACT_WRITE && wbusy_q) ? wq_q : in_qdiff[QW-1:0];

	// execution logic
	qrec_t         qs, qn_w, qn_r;
	logic          out_free, is_exec, is_read_st, is_wr, is_rd;
	logic          busy_n, drop_n, store, wr_rec;
	logic [QW-1:0] wq_n;
	logic [LW-1:0] woff_n, off_inc;
	logic [SW-1:0] wslot, rslot;
	logic          rd_hit, rd_end;
	logic          res_load;

	// memories
	logic [QRW-1:0]      qs_rdata, qs_wdata;
	logic                qs_we;
	logic [QW-1:0]       qs_waddr;
	logic                pay_en, pay_we;
	logic [AW-1:0]       pay_addr;
	logic [SAMPLE_W-1:0] pay_rdata;
	logic                len_en, len_we;
	logic [SW-1:0]       len_addr;
	logic [LW-1:0]       len_rdata;

	mqrb_vram #(.DW(QRW), .DEPTH(NUM_QUEUES), .AW(QW)) u_qrec (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (qs_we),
		.waddr  (qs_waddr),
		.wdata  (qs_wdata),
		.re     (in_acc),
		.raddr  (qs_raddr),
		.rdata  (qs_rdata)
	);

	mqrb_ram #(.DW(SAMPLE_W), .DEPTH(WORDS), .AW(AW)) u_payload (
		.clk   (clk),
		.en    (pay_en),
		.we    (pay_we),
		.addr  (pay_addr),
		.wdata (data_s1),
		.rdata (pay_rdata)
	);

	mqrb_ram #(.DW(LW), .DEPTH(SLOTS), .AW(SW)) u_length (
		.clk   (clk),
		.en    (len_en),
		.we    (len_we),
		.addr  (len_addr),
		.wdata (woff_n),
		.rdata (len_rdata)
	);

	assign qs         = qrec_t'(qs_rdata);
	assign out_free   = !m_valid_q || m_tready;
	assign is_exec    = (state_q == ST_EXEC);
	assign is_read_st = (state_q == ST_READ);
	assign is_wr      = (act_s1 == ACT_WRITE);
	assign is_rd      = (act_s1 == ACT_READ);

	// advance the packet being written
	always_comb begin
		qn_w   = qs;
		busy_n = wbusy_q;
		drop_n = wdrop_q;
		wq_n   = wq_q;
		woff_n = woff_q;
		wr_rec = 1'b0;
		if (!wbusy_q) begin
			busy_n = 1'b1;
			woff_n = '0;
			if (served_s1 && qs.latest < seq_s1) begin
				drop_n      = 1'b0;
				wq_n        = q_s1;
				qn_w.latest = seq_s1;
				wr_rec      = 1'b1;
				if (qs.total == CW'(RING_DEPTH)) begin
					qn_w.tail  = ring_inc(qs.tail);
					qn_w.total = qs.total - 1'b1;
					qn_w.roff  = '0;
				end
			end else begin
				drop_n = 1'b1;
			end
		end
		wslot = slot_of(wq_n, qn_w.head);
		store = !drop_n && (woff_n < LW'(WORDS_PER_ENTRY));
		if (store) begin
			woff_n = woff_n + 1'b1;
		end
		if (last_s1) begin
			if (!drop_n) begin
				qn_w.head  = ring_inc(qn_w.head);
				qn_w.total = qn_w.total + 1'b1;
				wr_rec     = 1'b1;
			end
			busy_n = 1'b0;
			drop_n = 1'b0;
		end
	end

	// read the oldest entry and pop it after its last word
	assign rd_hit  = served_s1 && (qs.total != '0);
	assign rslot   = slot_of(q_s1, qs.tail);
	assign off_inc = LW'(qs.roff) + 1'b1;
	assign rd_end  = off_inc >= len_rdata;

	always_comb begin
		qn_r = qs;
		if (rd_end) begin
			qn_r.tail  = ring_inc(qs.tail);
			qn_r.total = qs.total - 1'b1;
			qn_r.roff  = '0;
		end else begin
			qn_r.roff = off_inc[OW-1:0];
		end
	end

	// memory port control
	assign pay_we   = is_exec && is_wr;
	assign pay_en   = (is_exec && is_wr && store && out_free) || (is_exec && is_rd && rd_hit);
	assign pay_addr = is_wr ? word_of(wslot, woff_q[OW-1:0] & {OW{wbusy_q}})
	                        : word_of(rslot, qs.roff);
	assign len_we   = is_exec && is_wr;
	assign len_en   = (is_exec && is_wr && last_s1 && wr_rec && out_free)
	                  || (is_exec && is_rd && rd_hit);
	assign len_addr = is_wr ? wslot : rslot;
	assign qs_we    = out_free && ((is_exec && is_wr && wr_rec) || is_read_st);
	assign qs_waddr = is_wr ? wq_n : q_s1;
	assign qs_wdata = is_wr ? QRW'(qn_w) : QRW'(qn_r);

	// a result is ready at the end of execution, or after the payload fetch of a read hit
	assign res_load = out_free && ((is_exec && !(is_rd && rd_hit)) || is_read_st);

	// sequencer, configuration and write tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			base_q    <= '0;
			wbusy_q   <= 1'b0;
			wdrop_q   <= 1'b0;
			wq_q      <= '0;
			woff_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (is_rd && rd_hit) begin
						state_q <= ST_READ;
					end else if (out_free) begin
						state_q <= ST_IDLE;
						if (is_wr) begin
							wbusy_q <= busy_n;
							wdrop_q <= drop_n;
							wq_q    <= wq_n;
							woff_q  <= last_s1 ? '0 : woff_n;
						end
					end
				end
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the accepted request
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1    <= in_act;
			q_s1      <= in_qdiff[QW-1:0];
			served_s1 <= in_served;
			seq_s1    <= s_tdata[PORT_W +: SEQ_W];
			data_s1   <= s_tdata[PORT_W + SEQ_W +: SAMPLE_W];
			last_s1   <= s_tlast;
		end
	end

	// load the result register
	always_ff @(posedge clk) begin
		if (is_exec && out_free && !(is_rd && rd_hit)) begin
			dout_q  <= '0;
			dval_q  <= 1'b0;
			elast_q <= 1'b0;
			wacc_q  <= is_wr && store;
			cnt_q   <= (act_s1 == ACT_QUERY && served_s1) ? COUNT_W'(qs.total) : '0;
		end else if (is_read_st && out_free) begin
			dout_q  <= {pay_rdata[7:0], pay_rdata[15:8]};
			dval_q  <= 1'b1;
			elast_q <= rd_end;
			wacc_q  <= 1'b0;
			cnt_q   <= '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(M_TDATA_W - SAMPLE_W - COUNT_W)'(0), cnt_q, dout_q};
	assign m_tuser  = {wacc_q, dval_q};
	assign m_tlast  = elast_q;

endmodule

### src/mqrb_checker.sv
// Port-level checks for the multi-queue packet ring buffer result stream.
// Bound to multi_queue_packet_ring_buffer below; uses mqrb_pkg widths.
module mqrb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [mqrb_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [mqrb_pkg::M_TUSER_W-1:0] m_tuser,
	input logic                           m_tlast
);
	import mqrb_pkg::*;

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	// a result never reports both a read word and a stored write word
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("read and write flags both set");

	// entry end only comes with a returned word
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("entry end without data");

	// no sample without a read hit
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[SAMPLE_W-1:0] == '0)
		else $error("sample set on a result without data");

	// a count only on a query result
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[SAMPLE_W +: COUNT_W] != '0 |-> m_tuser == '0 && !m_tlast)
		else $error("count mixed with other fields");

endmodule

bind multi_queue_packet_ring_buffer mqrb_checker u_mqrb_checker (.*);
